// ===== design/dle_escaped_frame_parser_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef DLE_ESCAPED_FRAME_PARSER_UNIT_DEFINES_SVH
`define DLE_ESCAPED_FRAME_PARSER_UNIT_DEFINES_SVH

// Concurrent check on clk, switched off while rst is high.
`define DLEFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check on clk that also holds during reset.
`define DLEFP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/dlefp_pkg.sv =====
`default_nettype none

package dlefp_pkg;

  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned SeqWidth      = 7;
  localparam int unsigned KindWidth     = 3;
  localparam int unsigned CfgIndexWidth = 2;

  localparam logic [ByteWidth-1:0] START_CODE_RESET  = 8'h02;
  localparam logic [ByteWidth-1:0] ESCAPE_CODE_RESET = 8'h10;

  localparam logic [CfgIndexWidth-1:0] CFG_START_CODE  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ESCAPE_CODE = 2'd1;

  typedef enum logic [2:0] {
    PS_WAIT = 3'd0,
    PS_LEN  = 3'd1,
    PS_HDR  = 3'd2,
    PS_AHDR = 3'd3,
    PS_DATA = 3'd4,
    PS_CRC  = 3'd5
  } parse_state_t;

  typedef enum logic [KindWidth-1:0] {
    KIND_NONE = 3'd0,
    KIND_LEN  = 3'd1,
    KIND_HDR  = 3'd2,
    KIND_DATA = 3'd3,
    KIND_CRC  = 3'd4
  } field_kind_t;

  typedef struct packed {
    field_kind_t          field_kind;
    logic [ByteWidth-1:0] field_value;
    logic [ByteWidth-1:0] data_index;
    logic                 frame_done;
    logic [ByteWidth-1:0] frame_length;
    logic [SeqWidth-1:0]  seq_number;
    logic                 type_bit;
    logic                 is_ack;
  } result_t;

  typedef struct packed {
    logic [ByteWidth-1:0] start_code;
    logic [ByteWidth-1:0] escape_code;
  } codes_t;

endpackage

`default_nettype wire

// ===== design/dlefp_cfg_regs.sv =====
`default_nettype none

module dlefp_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dlefp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [dlefp_pkg::ByteWidth-1:0]     cfg_data,
  output dlefp_pkg::codes_t                        codes
);

  dlefp_pkg::codes_t codes_reg;

  assign cfg_ready = 1'b1;
  assign codes     = codes_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes_reg.start_code  <= dlefp_pkg::START_CODE_RESET;
      codes_reg.escape_code <= dlefp_pkg::ESCAPE_CODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dlefp_pkg::CFG_START_CODE:  codes_reg.start_code  <= cfg_data;
        dlefp_pkg::CFG_ESCAPE_CODE: codes_reg.escape_code <= cfg_data;
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/dlefp_in_stage.sv =====
`default_nettype none

module dlefp_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dlefp_pkg::ByteWidth-1:0] rx_byte,
  input  wire logic                            advance,
  output logic                                 held_valid,
  output logic [dlefp_pkg::ByteWidth-1:0]      held_byte
);

  logic                            byte_valid;
  logic [dlefp_pkg::ByteWidth-1:0] byte_reg;

  assign in_ready   = !byte_valid || advance;
  assign held_valid = byte_valid;
  assign held_byte  = byte_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/dlefp_parser.sv =====
`default_nettype none

module dlefp_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire logic [dlefp_pkg::ByteWidth-1:0] rx_byte,
  input  wire dlefp_pkg::codes_t               codes,
  output dlefp_pkg::result_t                   result
);

  dlefp_pkg::parse_state_t         state, state_next;
  logic                            escape_pending, escape_pending_next;
  logic [dlefp_pkg::ByteWidth-1:0] byte_count, byte_count_next;
  logic [dlefp_pkg::ByteWidth-1:0] length_reg, length_reg_next;
  logic [dlefp_pkg::SeqWidth-1:0]  seq_reg, seq_reg_next;
  logic                            type_reg, type_reg_next;

  logic                            take_byte;
  logic                            is_start;
  logic [dlefp_pkg::ByteWidth-1:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dlefp_pkg::PS_WAIT;
      escape_pending <= 1'b0;
      byte_count     <= '0;
      length_reg     <= '0;
      seq_reg        <= '0;
      type_reg       <= 1'b0;
    end else if (advance) begin
      state          <= state_next;
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      length_reg     <= length_reg_next;
      seq_reg        <= seq_reg_next;
      type_reg       <= type_reg_next;
    end
  end

  always_comb begin
    // an unescaped escape byte is swallowed; anything else is parsed
    take_byte = escape_pending || (rx_byte != codes.escape_code);
    is_start  = !escape_pending && (rx_byte == codes.start_code);
    count_inc = byte_count + 8'd1;

    state_next      = state;
    byte_count_next = byte_count;
    length_reg_next = length_reg;
    seq_reg_next    = seq_reg;
    type_reg_next   = type_reg;

    result.field_kind  = dlefp_pkg::KIND_NONE;
    result.field_value = '0;
    result.data_index  = '0;
    result.frame_done  = 1'b0;

    if (take_byte) begin
      if (is_start) begin
        state_next = dlefp_pkg::PS_LEN;
      end else begin
        unique case (state) inside
          dlefp_pkg::PS_LEN: begin
            length_reg_next    = rx_byte;
            byte_count_next    = '0;
            state_next         = (rx_byte != '0) ? dlefp_pkg::PS_HDR : dlefp_pkg::PS_AHDR;
            result.field_kind  = dlefp_pkg::KIND_LEN;
            result.field_value = rx_byte;
          end
          dlefp_pkg::PS_HDR, dlefp_pkg::PS_AHDR: begin
            seq_reg_next       = rx_byte[dlefp_pkg::ByteWidth-1:1];
            type_reg_next      = rx_byte[0];
            state_next         = (state == dlefp_pkg::PS_HDR) ? dlefp_pkg::PS_DATA
                                                              : dlefp_pkg::PS_CRC;
            result.field_kind  = dlefp_pkg::KIND_HDR;
            result.field_value = rx_byte;
          end
          dlefp_pkg::PS_DATA: begin
            result.field_kind  = dlefp_pkg::KIND_DATA;
            result.field_value = rx_byte;
            result.data_index  = byte_count;
            byte_count_next    = count_inc;
            if (count_inc >= length_reg) begin
              state_next = dlefp_pkg::PS_CRC;
            end
          end
          dlefp_pkg::PS_CRC: begin
            result.field_kind  = dlefp_pkg::KIND_CRC;
            result.field_value = rx_byte;
            result.frame_done  = 1'b1;
            state_next         = dlefp_pkg::PS_WAIT;
          end
          default: begin
            // waiting, or an unused code: ignore everything but a start
            state_next = dlefp_pkg::PS_WAIT;
          end
        endcase
      end
    end

    if (escape_pending) begin
      escape_pending_next = 1'b0;
    end else begin
      escape_pending_next = (rx_byte == codes.escape_code);
    end

    result.frame_length = length_reg_next;
    result.seq_number   = seq_reg_next;
    result.type_bit     = type_reg_next;
    result.is_ack       = (length_reg_next == '0);
  end

endmodule

`default_nettype wire

// ===== design/dlefp_out_stage.sv =====
`default_nettype none

module dlefp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire dlefp_pkg::result_t result_in,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dlefp_pkg::result_t      result_out
);

  logic               res_valid;
  dlefp_pkg::result_t res_reg;

  // a new result may enter when the register is empty or being drained
  assign room       = !res_valid || out_ready;
  assign out_valid  = res_valid;
  assign result_out = res_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_reg <= result_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/dle_escaped_frame_parser_unit.sv =====
// DLE-escaped frame receiver. Bytes enter on rx_byte with in_valid/in_ready;
// every accepted byte yields exactly one result transaction on
// out_valid/out_ready naming the field it filled (none, length, header,
// data, crc), the byte value, the payload index for data bytes, a frame_done
// flag on the CRC byte, and the captured length, sequence number, type bit
// and acknowledge flag as they stand after that byte.
// start_code and escape_code are written through cfg_valid/cfg_ready with
// cfg_index 0 or 1 and cfg_data; cfg_ready is always high. Write them only
// while no byte is in flight.
// Each accepted byte passes through the input register, then the result
// register; out_valid rises once the result register loads. Throughput: one
// byte per cycle while out_ready is high; the parse state advances in one
// step between the two registers.
// Reset clears the parse state, escape flag and captured fields, restores
// the codes to 0x02 and 0x10, and empties both registers.
// When out_ready is low the result holds; the input register takes one more
// byte if it is empty, after which in_ready drops until the result drains.
`default_nettype none

module dle_escaped_frame_parser_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [dlefp_pkg::ByteWidth-1:0]     rx_byte,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [dlefp_pkg::KindWidth-1:0]          field_kind,
  output logic [dlefp_pkg::ByteWidth-1:0]          field_value,
  output logic [dlefp_pkg::ByteWidth-1:0]          data_index,
  output logic                                     frame_done,
  output logic [dlefp_pkg::ByteWidth-1:0]          frame_length,
  output logic [dlefp_pkg::SeqWidth-1:0]           seq_number,
  output logic                                     type_bit,
  output logic                                     is_ack,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dlefp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [dlefp_pkg::ByteWidth-1:0]     cfg_data
);

  dlefp_pkg::codes_t               codes;
  dlefp_pkg::result_t              result_next;
  dlefp_pkg::result_t              result_q;
  logic                            held_valid;
  logic [dlefp_pkg::ByteWidth-1:0] held_byte;
  logic                            room;
  logic                            advance;

  assign advance = held_valid && room;

  dlefp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .codes     (codes)
  );

  dlefp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  dlefp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (held_byte),
    .codes   (codes),
    .result  (result_next)
  );

  dlefp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .result_in  (result_next),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  assign field_kind   = result_q.field_kind;
  assign field_value  = result_q.field_value;
  assign data_index   = result_q.data_index;
  assign frame_done   = result_q.frame_done;
  assign frame_length = result_q.frame_length;
  assign seq_number   = result_q.seq_number;
  assign type_bit     = result_q.type_bit;
  assign is_ack       = result_q.is_ack;

endmodule

`default_nettype wire

// ===== design/dlefp_checker.sv =====
`default_nettype none
`include "dle_escaped_frame_parser_unit_defines.svh"

module dlefp_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [dlefp_pkg::KindWidth-1:0] field_kind,
  input wire logic [dlefp_pkg::ByteWidth-1:0] field_value,
  input wire logic [dlefp_pkg::ByteWidth-1:0] data_index,
  input wire logic                            frame_done,
  input wire logic [dlefp_pkg::ByteWidth-1:0] frame_length,
  input wire logic [dlefp_pkg::SeqWidth-1:0]  seq_number,
  input wire logic                            type_bit,
  input wire logic                            is_ack
);

  `DLEFP_ASSERT(a_done_on_crc, out_valid && frame_done |-> field_kind == dlefp_pkg::KIND_CRC, "frame_done without crc field")

  `DLEFP_ASSERT(a_ack_matches_len, out_valid |-> is_ack == (frame_length == '0), "is_ack disagrees with frame_length")

  `DLEFP_ASSERT(a_index_only_data, out_valid && field_kind != dlefp_pkg::KIND_DATA |-> data_index == '0 && (field_kind != dlefp_pkg::KIND_NONE || field_value == '0), "stray index or value on result")

  `DLEFP_ASSERT(a_hold_while_stalled, out_valid && !out_ready |=> out_valid && $stable(field_kind) && $stable(field_value) && $stable(data_index) && $stable(seq_number) && $stable(type_bit), "result changed while stalled")

  `DLEFP_ASSERT_ALWAYS(a_empty_after_reset, $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind dle_escaped_frame_parser_unit dlefp_checker u_dlefp_checker (.*);

`default_nettype wire
